// File: rtl/core/ttc_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Target track confirmation package
// Widths, state codes, register map and the payload types that the
// interfaces and modules share.
// ----------------------------------------------------------------------------
package ttc_pkg;

   localparam int TIME_WIDTH     = 48;
   localparam int STAT_WIDTH     = 32;
   localparam int RUN_WIDTH      = 8;
   localparam int CODE_WIDTH     = 2;
   localparam int STATE_WIDTH    = 3;
   localparam int AGE_CFG_WIDTH  = 48;
   localparam int CMP_WIDTH      = (TIME_WIDTH > AGE_CFG_WIDTH) ? TIME_WIDTH : AGE_CFG_WIDTH;
   localparam int NUM_STATES     = 6;
   localparam int CSR_DATA_WIDTH = 64;
   localparam int CSR_ADDR_WIDTH = 5;
   localparam int CSR_IDX_LSB    = 3;
   localparam int CSR_IDX_WIDTH  = CSR_ADDR_WIDTH - CSR_IDX_LSB;

   typedef enum logic [STATE_WIDTH-1:0] {
      ST_NO_TARGET = 3'd0,
      ST_CANDIDATE = 3'd1,
      ST_DETECTED  = 3'd2,
      ST_LOST      = 3'd3,
      ST_STALE     = 3'd4,
      ST_INVALID   = 3'd5
   } track_state_type;

   typedef enum logic [CSR_IDX_WIDTH-1:0] {
      CSR_ACQUIRE_HIT = 2'd0,
      CSR_LOSE_MISS   = 2'd1,
      CSR_MAX_AGE     = 2'd2
   } csr_index_type;

   localparam logic [CODE_WIDTH-1:0] TCODE_DETECTED = 2'd0;
   localparam logic [CODE_WIDTH-1:0] TCODE_INVALID  = 2'd1;

   localparam logic [RUN_WIDTH-1:0] ACQUIRE_RESET = 8'd3;
   localparam logic [RUN_WIDTH-1:0] LOSE_RESET    = 8'd5;
   localparam logic [AGE_CFG_WIDTH-1:0] MAX_AGE_RESET = AGE_CFG_WIDTH'(100000000);

   typedef struct packed {
      logic                  action;
      logic [TIME_WIDTH-1:0] capture_time;
      logic [TIME_WIDTH-1:0] now_time;
      logic                  target_present;
      logic [CODE_WIDTH-1:0] target_state_code;
      logic                  target_valid;
      logic                  error_valid;
      logic                  error_state_invalid;
   } req_type;

   typedef struct packed {
      logic [STATE_WIDTH-1:0] track_state;
      logic                   control_valid;
      logic [TIME_WIDTH-1:0]  result_age;
      logic [RUN_WIDTH-1:0]   hit_run;
      logic [RUN_WIDTH-1:0]   miss_run;
      logic                   is_acquired;
      logic [TIME_WIDTH-1:0]  largest_age;
      logic [STAT_WIDTH-1:0]  items_processed;
      logic [STAT_WIDTH-1:0]  bad_timestamp_total;
      logic [STAT_WIDTH-1:0]  valid_control_total;
      logic [STAT_WIDTH-1:0]  state_occurrences;
   } rsp_type;

   typedef struct packed {
      logic [RUN_WIDTH-1:0]     acquire_hit_count;
      logic [RUN_WIDTH-1:0]     lose_miss_count;
      logic [AGE_CFG_WIDTH-1:0] max_age;
   } cfg_type;

   // A request after the timestamp check, as held in the first stage.
   typedef struct packed {
      logic                  clear;
      logic                  ts_ok;
      logic [TIME_WIDTH-1:0] age;
      logic                  present;
      logic [CODE_WIDTH-1:0] code;
      logic                  tvalid;
      logic                  evalid;
      logic                  einvalid;
   } stage_type;

   typedef struct packed {
      logic      go;
      stage_type item;
   } step_type;

   function automatic logic [STAT_WIDTH-1:0] stat_inc(input logic [STAT_WIDTH-1:0] v);
      return (&v) ? v : v + STAT_WIDTH'(1);
   endfunction

   function automatic logic [RUN_WIDTH-1:0] run_inc(input logic [RUN_WIDTH-1:0] v);
      return (&v) ? v : v + RUN_WIDTH'(1);
   endfunction

endpackage
`default_nettype wire

// File: rtl/core/ttc_if.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Target track confirmation channels
// Valid/ready channels for requests and results.
// ----------------------------------------------------------------------------
interface ttc_req_if;
   import ttc_pkg::*;
   logic    valid;
   logic    ready;
   req_type data;
   modport source (output valid, output data, input ready);
   modport sink (input valid, input data, output ready);
endinterface

interface ttc_rsp_if;
   import ttc_pkg::*;
   logic    valid;
   logic    ready;
   rsp_type data;
   modport source (output valid, output data, input ready);
   modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

// File: rtl/core/ttc_csr.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Target track confirmation registers
// APB-style register file for the acquire count, lose count and age limit.
// ----------------------------------------------------------------------------
module ttc_csr
   import ttc_pkg::*;
(
   input  wire logic                      clock,
   input  wire logic                      reset,
   input  wire logic                      psel,
   input  wire logic                      penable,
   input  wire logic                      pwrite,
   input  wire logic [CSR_ADDR_WIDTH-1:0] paddr,
   input  wire logic [CSR_DATA_WIDTH-1:0] pwdata,
   output logic      [CSR_DATA_WIDTH-1:0] prdata,
   output logic                           pready,
   output cfg_type                        cfg
);

   logic [RUN_WIDTH-1:0]     acquire_ff, acquire_in;
   logic [RUN_WIDTH-1:0]     lose_ff, lose_in;
   logic [AGE_CFG_WIDTH-1:0] max_age_ff, max_age_in;
   logic                     wr_en;
   csr_index_type            idx;

   assign pready = 1'b1;
   assign wr_en  = psel & penable & pwrite & pready;
   assign idx    = csr_index_type'(paddr[CSR_ADDR_WIDTH-1:CSR_IDX_LSB]);

   always_comb begin
      acquire_in = acquire_ff;
      lose_in    = lose_ff;
      max_age_in = max_age_ff;
      if (wr_en) begin
         unique case (idx)
            CSR_ACQUIRE_HIT: acquire_in = pwdata[RUN_WIDTH-1:0];
            CSR_LOSE_MISS:   lose_in    = pwdata[RUN_WIDTH-1:0];
            CSR_MAX_AGE:     max_age_in = pwdata[AGE_CFG_WIDTH-1:0];
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         acquire_ff <= ACQUIRE_RESET;
         lose_ff    <= LOSE_RESET;
         max_age_ff <= MAX_AGE_RESET;
      end else begin
         acquire_ff <= acquire_in;
         lose_ff    <= lose_in;
         max_age_ff <= max_age_in;
      end
   end

   always_comb begin
      unique case (idx)
         CSR_ACQUIRE_HIT: prdata = CSR_DATA_WIDTH'(acquire_ff);
         CSR_LOSE_MISS:   prdata = CSR_DATA_WIDTH'(lose_ff);
         CSR_MAX_AGE:     prdata = CSR_DATA_WIDTH'(max_age_ff);
         default:         prdata = '0;
      endcase
   end

   assign cfg.acquire_hit_count = acquire_ff;
   assign cfg.lose_miss_count   = lose_ff;
   assign cfg.max_age           = max_age_ff;

endmodule
`default_nettype wire

// File: rtl/core/ttc_tracker.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Target track confirmation tracker
// Hit and miss runs, acquisition, loss latch and statistics, one request
// per cycle while step.go is set.
// ----------------------------------------------------------------------------
module ttc_tracker
   import ttc_pkg::*;
(
   input  wire logic     clock,
   input  wire logic     reset,
   input  wire cfg_type  cfg,
   input  wire step_type step,
   output rsp_type       result
);

   logic [RUN_WIDTH-1:0]  hit_ff, hit_in;
   logic [RUN_WIDTH-1:0]  miss_ff, miss_in;
   logic                  acq_ff, acq_in;
   logic                  lost_ff, lost_in;
   logic [TIME_WIDTH-1:0] peak_ff, peak_in;
   logic [STAT_WIDTH-1:0] proc_ff, proc_in;
   logic [STAT_WIDTH-1:0] bad_ff, bad_in;
   logic [STAT_WIDTH-1:0] good_ff, good_in;
   logic [STAT_WIDTH-1:0] tot_ff [NUM_STATES];
   logic [STAT_WIDTH-1:0] tot_sel_in;

   stage_type       it;
   logic            stale, raw_det, raw_inv, ctrl, miss;
   logic [RUN_WIDTH-1:0] miss_inc, hit_inc;
   track_state_type st;

   assign it = step.item;

   always_comb begin
      stale    = it.ts_ok && (CMP_WIDTH'(it.age) > CMP_WIDTH'(cfg.max_age));
      raw_det  = it.present && (it.code == TCODE_DETECTED) && it.tvalid && it.evalid;
      raw_inv  = (it.present && (it.code == TCODE_INVALID)) || it.einvalid || !it.ts_ok;
      miss_inc = run_inc(miss_ff);
      hit_inc  = run_inc(hit_ff);
      miss     = stale || raw_inv || !raw_det;

      hit_in  = hit_ff;
      miss_in = miss_ff;
      acq_in  = acq_ff;
      lost_in = lost_ff;
      st      = ST_NO_TARGET;

      if (miss) begin
         hit_in  = '0;
         miss_in = miss_inc;
         if (acq_ff && (miss_inc >= cfg.lose_miss_count)) begin
            acq_in  = 1'b0;
            lost_in = 1'b1;
         end
         if (stale) begin
            st = ST_STALE;
         end else if (raw_inv) begin
            st = ST_INVALID;
         end else begin
            st = lost_in ? ST_LOST : ST_NO_TARGET;
         end
      end else begin
         miss_in = '0;
         hit_in  = hit_inc;
         lost_in = 1'b0;
         if (acq_ff || (hit_inc >= cfg.acquire_hit_count)) begin
            acq_in = 1'b1;
            st     = ST_DETECTED;
         end else begin
            st = ST_CANDIDATE;
         end
      end

      ctrl       = (st == ST_DETECTED) && it.evalid;
      peak_in    = (it.age > peak_ff) ? it.age : peak_ff;
      proc_in    = stat_inc(proc_ff);
      bad_in     = it.ts_ok ? bad_ff : stat_inc(bad_ff);
      good_in    = ctrl ? stat_inc(good_ff) : good_ff;
      tot_sel_in = stat_inc(tot_ff[st]);

      result.track_state         = st;
      result.control_valid       = ctrl;
      result.result_age          = it.age;
      result.hit_run             = hit_in;
      result.miss_run            = miss_in;
      result.is_acquired         = acq_in;
      result.largest_age         = peak_in;
      result.items_processed     = proc_in;
      result.bad_timestamp_total = bad_in;
      result.valid_control_total = good_in;
      result.state_occurrences   = tot_sel_in;

      // A clear request answers with an all-zero result.
      if (it.clear) begin
         result = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset || (step.go && it.clear)) begin
         hit_ff  <= '0;
         miss_ff <= '0;
         acq_ff  <= 1'b0;
         lost_ff <= 1'b0;
         peak_ff <= '0;
         proc_ff <= '0;
         bad_ff  <= '0;
         good_ff <= '0;
         for (int i = 0; i < NUM_STATES; i++) begin
            tot_ff[i] <= '0;
         end
      end else if (step.go) begin
         hit_ff     <= hit_in;
         miss_ff    <= miss_in;
         acq_ff     <= acq_in;
         lost_ff    <= lost_in;
         peak_ff    <= peak_in;
         proc_ff    <= proc_in;
         bad_ff     <= bad_in;
         good_ff    <= good_in;
         tot_ff[st] <= tot_sel_in;
      end
   end

endmodule
`default_nettype wire

// File: rtl/core/target_track_confirmation_unit.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Target track confirmation unit
// Confirms or drops a tracked target from consecutive hits and misses of
// perception results and keeps age and outcome statistics.
// ----------------------------------------------------------------------------
//
//   Port group   Direction   Handshake            Moves
//   req          in          valid/ready          one perception request
//   rsp          out         valid/ready          one result per request
//   APB (p*)     in/out      psel/penable/pready  register writes and reads
//
// A request is taken on any cycle in which the first stage is empty or
// moving on, so one request per clock is sustained while rsp is ready.
// Each request passes two register stages, the first stage register and
// the result register: the first stage registers the age subtraction and
// timestamp check, the second updates the tracking state and statistics
// and loads the result register. Reset is synchronous and active high; it
// clears all tracking state and restores the register defaults.
// When rsp is stalled the result register holds, the first stage still
// accepts one request, and only then does req.ready drop.
//
// The tracking state (runs, acquired flag, loss latch, peak age and totals)
// is read and written in the same cycle, so consecutive requests see each
// other's updates without bypassing. A clear request zeroes all of it but
// leaves the registers alone, and its result is all zero.
// ----------------------------------------------------------------------------
module target_track_confirmation_unit
   import ttc_pkg::*;
(
   input  wire logic                      clock,
   input  wire logic                      reset,
   ttc_req_if.sink                        req,
   ttc_rsp_if.source                      rsp,
   input  wire logic                      psel,
   input  wire logic                      penable,
   input  wire logic                      pwrite,
   input  wire logic [CSR_ADDR_WIDTH-1:0] paddr,
   input  wire logic [CSR_DATA_WIDTH-1:0] pwdata,
   output logic      [CSR_DATA_WIDTH-1:0] prdata,
   output logic                           pready
);

   cfg_type   cfg;
   step_type  step;
   rsp_type   result;

   logic      a_vld_ff, a_vld_in;
   stage_type a_ff, a_in;
   logic      o_vld_ff, o_vld_in;
   rsp_type   o_ff, o_in;

   logic      advance;
   logic      take;
   logic [TIME_WIDTH:0] diff;

   ttc_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready),
      .cfg     (cfg)
   );

   // The output stage moves whenever the result register is free or drained.
   assign advance   = !o_vld_ff || rsp.ready;
   assign req.ready = !a_vld_ff || advance;
   assign take      = req.valid && req.ready;

   // First stage: age and timestamp check. The borrow of the widened
   // subtraction flags a capture time in the future.
   always_comb begin
      diff       = {1'b0, req.data.now_time} - {1'b0, req.data.capture_time};
      a_in.clear = req.data.action;
      a_in.ts_ok = (req.data.capture_time != '0) && !diff[TIME_WIDTH];
      a_in.age   = a_in.ts_ok ? diff[TIME_WIDTH-1:0] : '0;
      a_in.present  = req.data.target_present;
      a_in.code     = req.data.target_state_code;
      a_in.tvalid   = req.data.target_valid;
      a_in.evalid   = req.data.error_valid;
      a_in.einvalid = req.data.error_state_invalid;
      a_vld_in      = req.ready ? req.valid : a_vld_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         a_vld_ff <= 1'b0;
      end else begin
         a_vld_ff <= a_vld_in;
      end
   end

   always_ff @(posedge clock) begin
      if (take) begin
         a_ff <= a_in;
      end
   end

   // Second stage: tracking update into the result register.
   assign step.go   = a_vld_ff && advance;
   assign step.item = a_ff;

   ttc_tracker u_tracker (
      .clock  (clock),
      .reset  (reset),
      .cfg    (cfg),
      .step   (step),
      .result (result)
   );

   always_comb begin
      o_vld_in = advance ? a_vld_ff : o_vld_ff;
      o_in     = step.go ? result : o_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         o_vld_ff <= 1'b0;
      end else begin
         o_vld_ff <= o_vld_in;
      end
   end

   always_ff @(posedge clock) begin
      o_ff <= o_in;
   end

   assign rsp.valid = o_vld_ff;
   assign rsp.data  = o_ff;

   // A held first stage keeps its request until the output side frees up.
   a_hold: assert property (@(posedge clock) disable iff (reset)
      (a_vld_ff && !advance) |=> a_vld_ff)
      else $error("first stage dropped a request while stalled");

   // A detected result always reports an acquired target.
   det_acq: assert property (@(posedge clock) disable iff (reset)
      (rsp.valid && (rsp.data.track_state == ST_DETECTED)) |-> rsp.data.is_acquired)
      else $error("detected result without acquisition");

   // Control is only valid in the detected state.
   ctrl_det: assert property (@(posedge clock) disable iff (reset)
      (rsp.valid && rsp.data.control_valid) |-> (rsp.data.track_state == ST_DETECTED))
      else $error("control valid outside detected state");

   // A candidate has at least one hit and is not acquired yet.
   cand_run: assert property (@(posedge clock) disable iff (reset)
      (rsp.valid && (rsp.data.track_state == ST_CANDIDATE))
         |-> ((rsp.data.hit_run != '0) && !rsp.data.is_acquired))
      else $error("candidate result with inconsistent run state");

   // The peak age never falls below the age of the result it comes with.
   peak_ge: assert property (@(posedge clock) disable iff (reset)
      rsp.valid |-> (rsp.data.largest_age >= rsp.data.result_age))
      else $error("largest age below result age");

endmodule
`default_nettype wire

// File: tb/sv/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Target track confirmation unit testbench
// Drives perception requests and register writes into the unit, predicts
// every result with an independent model of the hit/miss tracking and the
// statistics, and compares each returned result field by field.
// ----------------------------------------------------------------------------
module testbench;
   import ttc_pkg::*;

   localparam logic [TIME_WIDTH-1:0] TIME_MAX = '1;

   // Raw target codes that mean neither detected nor invalid.
   localparam logic [CODE_WIDTH-1:0] TCODE_OTHER = 2'd2;
   localparam logic [CODE_WIDTH-1:0] TCODE_SPARE = 2'd3;

   // The scoreboard keeps its own copy of the registers and of the tracking
   // state. Every accepted request is turned into the result the unit must
   // return, and results are checked strictly in request order.
   class track_checker;
      logic [RUN_WIDTH-1:0]     acquire_need;
      logic [RUN_WIDTH-1:0]     lose_misses;
      logic [AGE_CFG_WIDTH-1:0] max_age;

      logic [RUN_WIDTH-1:0]  hit_run;
      logic [RUN_WIDTH-1:0]  miss_run;
      logic                  acquired;
      logic                  lost_seen;
      logic [TIME_WIDTH-1:0] peak_age;
      logic [STAT_WIDTH-1:0] processed;
      logic [STAT_WIDTH-1:0] bad_times;
      logic [STAT_WIDTH-1:0] good_controls;
      logic [STAT_WIDTH-1:0] state_totals[NUM_STATES];

      rsp_type pending_tracks[$];
      int      checked;
      int      failures;
      int      state_seen[NUM_STATES];

      function new();
         acquire_need = ACQUIRE_RESET;
         lose_misses  = LOSE_RESET;
         max_age      = MAX_AGE_RESET;
         clear_tracking();
         checked  = 0;
         failures = 0;
         foreach (state_seen[s]) state_seen[s] = 0;
      endfunction

      function void set_register(csr_index_type idx, logic [CSR_DATA_WIDTH-1:0] value);
         case (idx)
            CSR_ACQUIRE_HIT: acquire_need = value[RUN_WIDTH-1:0];
            CSR_LOSE_MISS:   lose_misses  = value[RUN_WIDTH-1:0];
            CSR_MAX_AGE:     max_age      = value[AGE_CFG_WIDTH-1:0];
            default: ;
         endcase
      endfunction

      function logic [STAT_WIDTH-1:0] bump(logic [STAT_WIDTH-1:0] v);
         return (v == '1) ? v : v + STAT_WIDTH'(1);
      endfunction

      function void clear_tracking();
         hit_run       = '0;
         miss_run      = '0;
         acquired      = 1'b0;
         lost_seen     = 1'b0;
         peak_age      = '0;
         processed     = '0;
         bad_times     = '0;
         good_controls = '0;
         foreach (state_totals[s]) state_totals[s] = '0;
      endfunction

      // A miss breaks the hit run; an acquired target that has missed often
      // enough is dropped and the loss is remembered.
      function void note_miss();
         hit_run = '0;
         if (miss_run != '1) miss_run = miss_run + RUN_WIDTH'(1);
         if (acquired && miss_run >= lose_misses) begin
            acquired  = 1'b0;
            lost_seen = 1'b1;
         end
      endfunction

      function void accept_request(req_type r);
         rsp_type               want;
         logic                  ts_ok;
         logic                  stale;
         logic                  seen;
         logic                  bad;
         logic [TIME_WIDTH-1:0] age;
         track_state_type       st;
         want = '0;
         if (r.action) begin
            clear_tracking();
            pending_tracks.push_back(want);
            return;
         end
         ts_ok = (r.capture_time != '0) && (r.now_time >= r.capture_time);
         age   = ts_ok ? r.now_time - r.capture_time : '0;
         stale = ts_ok && (age > max_age);
         seen  = r.target_present && (r.target_state_code == TCODE_DETECTED) &&
                 r.target_valid && r.error_valid;
         bad   = (r.target_present && (r.target_state_code == TCODE_INVALID)) ||
                 r.error_state_invalid || !ts_ok;
         processed = bump(processed);
         if (!ts_ok) bad_times = bump(bad_times);
         if (stale) begin
            note_miss();
            st = ST_STALE;
         end else if (bad) begin
            note_miss();
            st = ST_INVALID;
         end else if (seen) begin
            miss_run  = '0;
            if (hit_run != '1) hit_run = hit_run + RUN_WIDTH'(1);
            lost_seen = 1'b0;
            if (acquired || hit_run >= acquire_need) begin
               acquired = 1'b1;
               st       = ST_DETECTED;
            end else begin
               st = ST_CANDIDATE;
            end
         end else begin
            note_miss();
            st = lost_seen ? ST_LOST : ST_NO_TARGET;
         end
         if (age > peak_age) peak_age = age;
         state_totals[st] = bump(state_totals[st]);
         if (st == ST_DETECTED && r.error_valid) good_controls = bump(good_controls);

         want.track_state         = st;
         want.control_valid       = (st == ST_DETECTED) && r.error_valid;
         want.result_age          = age;
         want.hit_run             = hit_run;
         want.miss_run            = miss_run;
         want.is_acquired         = acquired;
         want.largest_age         = peak_age;
         want.items_processed     = processed;
         want.bad_timestamp_total = bad_times;
         want.valid_control_total = good_controls;
         want.state_occurrences   = state_totals[st];
         pending_tracks.push_back(want);
      endfunction

      function void compare_field(string field, logic [63:0] want, logic [63:0] got);
         if (want !== got) begin
            $error("%s mismatch: expected %0h actual %0h", field, want, got);
            failures++;
         end
      endfunction

      function void check_result(rsp_type got);
         rsp_type want;
         if (pending_tracks.size() == 0) begin
            $error("result with no request waiting, track_state %0d", got.track_state);
            failures++;
            return;
         end
         want = pending_tracks.pop_front();
         checked++;
         compare_field("track_state", want.track_state, got.track_state);
         compare_field("control_valid", want.control_valid, got.control_valid);
         compare_field("result_age", want.result_age, got.result_age);
         compare_field("hit_run", want.hit_run, got.hit_run);
         compare_field("miss_run", want.miss_run, got.miss_run);
         compare_field("is_acquired", want.is_acquired, got.is_acquired);
         compare_field("largest_age", want.largest_age, got.largest_age);
         compare_field("items_processed", want.items_processed, got.items_processed);
         compare_field("bad_timestamp_total", want.bad_timestamp_total,
                       got.bad_timestamp_total);
         compare_field("valid_control_total", want.valid_control_total,
                       got.valid_control_total);
         compare_field("state_occurrences", want.state_occurrences, got.state_occurrences);
         if (got.track_state < NUM_STATES) state_seen[got.track_state]++;
      endfunction
   endclass

   logic                      clock;
   logic                      reset;
   logic                      psel;
   logic                      penable;
   logic                      pwrite;
   logic [CSR_ADDR_WIDTH-1:0] paddr;
   logic [CSR_DATA_WIDTH-1:0] pwdata;
   logic [CSR_DATA_WIDTH-1:0] prdata;
   logic                      pready;

   ttc_req_if req_if ();
   ttc_rsp_if rsp_if ();

   track_checker tracking;

   // When quiet is set neither side inserts random gaps. A nonzero
   // hold_cycles makes the result side refuse results for that many cycles;
   // the receiving process counts it down itself.
   bit quiet;
   int hold_cycles;
   int settings_used;

   target_track_confirmation_unit dut (
      .clock   (clock),
      .reset   (reset),
      .req     (req_if),
      .rsp     (rsp_if),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready)
   );

   initial clock = 1'b0;
   always #6 clock = ~clock;

   // Nothing may be left hanging if the unit locks up.
   initial begin
      #(2_000_000);
      $display("TEST FAILED");
      $finish;
   end

   // Result side. Results are sampled at the rising edge and ready is
   // changed at the falling edge, so neither side races the other.
   initial begin
      rsp_if.ready = 1'b0;
      forever begin
         @(posedge clock);
         if (!reset && rsp_if.valid && rsp_if.ready) tracking.check_result(rsp_if.data);
         @(negedge clock);
         if (hold_cycles > 0) begin
            rsp_if.ready = 1'b0;
            hold_cycles--;
         end else begin
            rsp_if.ready = quiet || ($urandom_range(99) >= 15);
         end
      end
   end

   function automatic logic [TIME_WIDTH-1:0] rand_time();
      logic [63:0] w;
      w = {$urandom, $urandom};
      return w[TIME_WIDTH-1:0];
   endfunction

   // An age that is not stale under the current max_age, mostly small so
   // that the interesting part of the range is hit often.
   function automatic logic [TIME_WIDTH-1:0] fresh_age();
      logic [TIME_WIDTH-1:0] lim;
      logic [TIME_WIDTH-1:0] short_age;
      lim = tracking.max_age;
      if (lim == TIME_MAX) lim = TIME_MAX - TIME_WIDTH'(1);
      short_age = TIME_WIDTH'($urandom_range(1000));
      case ($urandom_range(9))
         0:       return lim;
         1, 2, 3: return rand_time() % (lim + TIME_WIDTH'(1));
         default: return (short_age > lim) ? lim : short_age;
      endcase
   endfunction

   // An age just past max_age or anywhere above it. The caller makes sure
   // that such an age exists.
   function automatic logic [TIME_WIDTH-1:0] stale_age();
      logic [TIME_WIDTH-1:0] lim;
      logic [TIME_WIDTH-1:0] span;
      lim  = tracking.max_age;
      span = TIME_MAX - TIME_WIDTH'(1) - lim;
      if ($urandom_range(2) == 0) return lim + TIME_WIDTH'(1);
      return lim + TIME_WIDTH'(1) + rand_time() % span;
   endfunction

   // A request with a valid timestamp pair of the given age and clear flags.
   function automatic req_type timed_request(input logic [TIME_WIDTH-1:0] age);
      req_type               r;
      logic [TIME_WIDTH-1:0] cap;
      r   = '0;
      cap = rand_time();
      if (cap == '0) cap = TIME_WIDTH'(1);
      if (cap > TIME_MAX - age) cap = TIME_MAX - age;
      r.capture_time = cap;
      r.now_time     = cap + age;
      return r;
   endfunction

   function automatic req_type with_noise_flags(input req_type r);
      r.target_present      = 1'($urandom_range(1));
      r.target_state_code   = CODE_WIDTH'($urandom_range(3));
      r.target_valid        = 1'($urandom_range(1));
      r.error_valid         = 1'($urandom_range(1));
      r.error_state_invalid = 1'($urandom_range(1));
      return r;
   endfunction

   function automatic req_type make_request(input logic act,
                                            input logic [TIME_WIDTH-1:0] cap,
                                            input logic [TIME_WIDTH-1:0] now,
                                            input logic present,
                                            input logic [CODE_WIDTH-1:0] code,
                                            input logic tvalid, input logic evalid,
                                            input logic einvalid);
      req_type r;
      r.action              = act;
      r.capture_time        = cap;
      r.now_time            = now;
      r.target_present      = present;
      r.target_state_code   = code;
      r.target_valid        = tvalid;
      r.error_valid         = evalid;
      r.error_state_invalid = einvalid;
      return r;
   endfunction

   function automatic req_type detection_request();
      req_type r;
      r = timed_request(fresh_age());
      r.target_present    = 1'b1;
      r.target_state_code = TCODE_DETECTED;
      r.target_valid      = 1'b1;
      r.error_valid       = 1'b1;
      return r;
   endfunction

   // Good timestamp but the observation falls short of a detection.
   function automatic req_type near_miss();
      req_type r;
      int      pick;
      r    = timed_request(fresh_age());
      pick = $urandom_range(2);
      r.target_present    = 1'($urandom_range(1));
      r.target_state_code = (pick == 0) ? TCODE_DETECTED : (pick == 1) ? TCODE_OTHER
                                                                       : TCODE_SPARE;
      r.target_valid      = 1'($urandom_range(1));
      r.error_valid       = 1'($urandom_range(1));
      if (r.target_present && r.target_state_code == TCODE_DETECTED &&
          r.target_valid && r.error_valid) begin
         case ($urandom_range(2))
            0:       r.target_present = 1'b0;
            1:       r.target_valid   = 1'b0;
            default: r.error_valid    = 1'b0;
         endcase
      end
      return r;
   endfunction

   function automatic req_type invalid_report();
      req_type r;
      r = with_noise_flags(timed_request(fresh_age()));
      if ($urandom_range(1)) begin
         r.target_present    = 1'b1;
         r.target_state_code = TCODE_INVALID;
      end else begin
         r.error_state_invalid = 1'b1;
      end
      return r;
   endfunction

   // Capture time missing or later than the current time.
   function automatic req_type bad_timestamp();
      req_type               r;
      logic [TIME_WIDTH-1:0] a;
      logic [TIME_WIDTH-1:0] b;
      r = with_noise_flags('0);
      a = rand_time();
      b = rand_time();
      if ($urandom_range(1)) begin
         r.capture_time = '0;
         r.now_time     = a;
      end else begin
         if (a == b) b = a ^ TIME_WIDTH'(1);
         r.capture_time = (a > b) ? a : b;
         r.now_time     = (a > b) ? b : a;
      end
      return r;
   endfunction

   function automatic req_type stale_request();
      if (tracking.max_age >= TIME_MAX - TIME_WIDTH'(1)) return bad_timestamp();
      return with_noise_flags(timed_request(stale_age()));
   endfunction

   function automatic req_type miss_request();
      case ($urandom_range(3))
         0:       return near_miss();
         1:       return stale_request();
         2:       return bad_timestamp();
         default: return invalid_report();
      endcase
   endfunction

   function automatic req_type clear_request();
      req_type r;
      r = with_noise_flags('0);
      r.action       = 1'b1;
      r.capture_time = rand_time();
      r.now_time     = rand_time();
      return r;
   endfunction

   function automatic req_type noise_request();
      req_type r;
      r = with_noise_flags('0);
      r.capture_time = rand_time();
      r.now_time     = rand_time();
      return r;
   endfunction

   function automatic req_type random_request();
      case ($urandom_range(9))
         0:             return clear_request();
         1:             return noise_request();
         2, 3, 4, 5:    return detection_request();
         default:       return miss_request();
      endcase
   endfunction

   // Offers one request and returns at the falling edge after it was taken.
   // Valid stays high afterwards so back-to-back requests need no toggle;
   // only a random gap or the end of a phase lowers it.
   task automatic send_request(input req_type item);
      while (!quiet && $urandom_range(99) < 15) begin
         req_if.valid = 1'b0;
         @(negedge clock);
      end
      req_if.data  = item;
      req_if.valid = 1'b1;
      do @(posedge clock); while (!req_if.ready);
      tracking.accept_request(item);
      @(negedge clock);
   endtask

   // Most of the traffic comes as runs: streaks of detections and streaks of
   // misses up to two past the acquire or lose count (at most twelve), and odd
   // requests in between, clears and plain noise among them.
   task automatic random_traffic(input int count);
      int sent;
      int run_len;
      int pick;
      sent = 0;
      while (sent < count) begin
         pick = $urandom_range(9);
         if (pick < 5) begin
            run_len = $urandom_range(1, (tracking.acquire_need > 10) ? 12
                                        : int'(tracking.acquire_need) + 2);
            repeat (run_len) send_request(detection_request());
         end else if (pick < 8) begin
            run_len = $urandom_range(1, (tracking.lose_misses > 10) ? 12
                                        : int'(tracking.lose_misses) + 2);
            repeat (run_len) send_request(miss_request());
         end else begin
            run_len = 1;
            send_request(random_request());
         end
         sent += run_len;
      end
   endtask

   // Stops offering requests and waits until every result is back. All
   // requests produce a result, so the checker's pending list runs empty.
   task automatic finish_phase();
      req_if.valid = 1'b0;
      while (tracking.pending_tracks.size() != 0) @(negedge clock);
      repeat (4) @(negedge clock);
   endtask

   // One APB write followed by a read of the same register. Both transfers
   // complete at the rising edge of the access phase with pready high.
   task automatic write_register(input csr_index_type idx,
                                 input logic [CSR_DATA_WIDTH-1:0] value);
      logic [CSR_DATA_WIDTH-1:0] mask;
      mask = (idx == CSR_MAX_AGE) ?
             {{(CSR_DATA_WIDTH-AGE_CFG_WIDTH){1'b0}}, {AGE_CFG_WIDTH{1'b1}}} :
             {{(CSR_DATA_WIDTH-RUN_WIDTH){1'b0}}, {RUN_WIDTH{1'b1}}};
      psel    = 1'b1;
      penable = 1'b0;
      pwrite  = 1'b1;
      paddr   = CSR_ADDR_WIDTH'(idx) << CSR_IDX_LSB;
      pwdata  = value;
      @(negedge clock);
      penable = 1'b1;
      do @(posedge clock); while (!pready);
      tracking.set_register(idx, value);
      @(negedge clock);
      penable = 1'b0;
      pwrite  = 1'b0;
      @(negedge clock);
      penable = 1'b1;
      do @(posedge clock); while (!pready);
      tracking.compare_field("register readback", value & mask, prdata & mask);
      @(negedge clock);
      psel    = 1'b0;
      penable = 1'b0;
   endtask

   task automatic apply_settings(input logic [CSR_DATA_WIDTH-1:0] acquire,
                                 input logic [CSR_DATA_WIDTH-1:0] lose,
                                 input logic [CSR_DATA_WIDTH-1:0] age_limit);
      write_register(CSR_ACQUIRE_HIT, acquire);
      write_register(CSR_LOSE_MISS, lose);
      write_register(CSR_MAX_AGE, age_limit);
      settings_used++;
   endtask

   initial begin
      int i;
      reset         = 1'b1;
      psel          = 1'b0;
      penable       = 1'b0;
      pwrite        = 1'b0;
      paddr         = '0;
      pwdata        = '0;
      req_if.valid  = 1'b0;
      req_if.data   = '0;
      quiet         = 1'b0;
      hold_cycles   = 0;
      settings_used = 1;
      tracking      = new();
      repeat (4) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // Directed requests under the reset register values (acquire after
      // three hits, lose after five misses). The first three detections
      // acquire the target, including an age of exactly max_age and a pair
      // of all-ones timestamps.
      send_request(make_request(0, 1, 1, 1, TCODE_DETECTED, 1, 1, 0));
      send_request(make_request(0, 1000, 1000 + MAX_AGE_RESET, 1, TCODE_DETECTED, 1, 1, 0));
      send_request(make_request(0, TIME_MAX, TIME_MAX, 1, TCODE_DETECTED, 1, 1, 0));
      // Five kinds of miss in a row: a missing error flag, no target, an
      // unknown code, an invalid observation flag and an invalid code. The
      // fifth one drops the acquired target.
      send_request(make_request(0, 20, 30, 1, TCODE_DETECTED, 1, 0, 0));
      send_request(make_request(0, 20, 30, 0, TCODE_DETECTED, 1, 1, 0));
      send_request(make_request(0, 20, 30, 1, TCODE_SPARE, 1, 1, 0));
      send_request(make_request(0, 20, 30, 1, TCODE_DETECTED, 0, 1, 0));
      send_request(make_request(0, 20, 30, 1, TCODE_INVALID, 1, 1, 0));
      // The loss is now latched, so a plain miss reports the lost state.
      send_request(make_request(0, 40, 50, 0, TCODE_OTHER, 0, 0, 0));
      // An invalid error state beats a detection, staleness beats that, and
      // a missing or future capture time counts as invalid.
      send_request(make_request(0, 40, 50, 1, TCODE_DETECTED, 1, 1, 1));
      send_request(make_request(0, 5, 6 + MAX_AGE_RESET, 1, TCODE_DETECTED, 1, 1, 0));
      send_request(make_request(0, 0, TIME_MAX, 1, TCODE_DETECTED, 1, 1, 0));
      send_request(make_request(0, TIME_MAX, TIME_MAX - 1, 1, TCODE_DETECTED, 1, 1, 0));
      // A detection releases the latched loss.
      send_request(make_request(0, TIME_MAX - 50, TIME_MAX, 1, TCODE_DETECTED, 1, 1, 0));
      // A clear with every other field set to ones, then requests that
      // start the tracking over, one with the largest possible age.
      send_request(make_request(1, TIME_MAX, TIME_MAX, 1, TCODE_SPARE, 1, 1, 1));
      send_request(make_request(0, 0, 0, 0, TCODE_DETECTED, 0, 0, 0));
      send_request(make_request(0, 1, TIME_MAX, 1, TCODE_DETECTED, 1, 1, 0));
      send_request(make_request(0, 100, 200, 1, TCODE_DETECTED, 1, 1, 0));
      random_traffic(25);

      // One hit acquires, one miss loses, and nothing with a valid
      // timestamp can go stale. The first part runs without any gaps.
      finish_phase();
      apply_settings(1, 1, CSR_DATA_WIDTH'(TIME_MAX));
      quiet = 1'b1;
      random_traffic(20);
      quiet = 1'b0;
      random_traffic(15);

      // The widest counts and an age limit of one. A long streak of
      // detections saturates the hit run and only just acquires; the miss
      // streak that follows saturates the miss run and loses the target on
      // its last allowed miss.
      finish_phase();
      apply_settings(255, 255, 1);
      quiet = 1'b1;
      repeat (258) send_request(detection_request());
      repeat (257) send_request(miss_request());
      quiet = 1'b0;

      // Zero counts: the first detection acquires and the first miss loses.
      // A zero age limit makes every nonzero age stale.
      finish_phase();
      apply_settings(0, 0, 0);
      random_traffic(25);

      // Moderate random settings. The first phase starts with the result
      // side held off long enough for the unit to fill and stall its input;
      // in the second the sender stops halfway until every result is back.
      for (i = 0; i < 3; i++) begin
         finish_phase();
         apply_settings(CSR_DATA_WIDTH'($urandom_range(2, 6)),
                        CSR_DATA_WIDTH'($urandom_range(2, 8)),
                        CSR_DATA_WIDTH'($urandom_range(1) ? rand_time()
                                        : TIME_WIDTH'($urandom_range(100, 5000))));
         if (i == 0) hold_cycles = 80;
         if (i == 1) begin
            random_traffic(10);
            finish_phase();
         end
         random_traffic(12);
      end

      finish_phase();
      $display("Run summary: %0d results checked under %0d register settings, %0d mismatches.",
               tracking.checked, settings_used, tracking.failures);
      $display("Results by state: none %0d, candidate %0d, detected %0d, lost %0d, %s %0d, %s %0d.",
               tracking.state_seen[ST_NO_TARGET], tracking.state_seen[ST_CANDIDATE],
               tracking.state_seen[ST_DETECTED], tracking.state_seen[ST_LOST],
               "stale", tracking.state_seen[ST_STALE],
               "invalid", tracking.state_seen[ST_INVALID]);
      if (tracking.failures == 0 && tracking.pending_tracks.size() == 0) begin
         $display("TEST PASSED");
      end else begin
         $display("TEST FAILED");
      end
      $finish;
   end
endmodule
